// File: rtl/core/skt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg: shared definitions for the sorted key table
// Sizes, operation and status codes, and the command and status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package skt_pkg;

	// Table sizing
	localparam int CAPACITY  = 16;
	localparam int KEY_BITS  = 32;
	localparam int DATA_BITS = 32;

	// Port fields are 32 bits wide; stored widths never exceed that
	localparam int KEY_W  = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int DATA_W = (DATA_BITS < 32) ? DATA_BITS : 32;
	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	// Operation codes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;
	localparam logic [1:0] MODE_ENUM   = 2'd3;

	// Result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_DUP      = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	// Controller to datapath
	typedef struct packed {
		logic load;         // capture request, open search window
		logic search_step;  // one binary search step
		logic resolve;      // apply insert/remove/lookup and emit result
		logic enum_step;    // emit one entry of the enumeration
	} skt_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic search_done;  // search window has closed
		logic enum_last;    // current enumeration result is the final one
	} skt_stat_t;

endpackage

// File: rtl/core/sorted_key_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_core: ordered key/payload table with binary search
// Insert, remove, lookup and enumerate over up to CAPACITY entries kept in
// ascending key order.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Insert, remove and
// lookup run a binary search over the filled entries, one step a cycle, and a
// resolve step, holding busy through both, and give one result on the cycle
// after resolve; insert and remove shift all entry lanes together at resolve.
// Enumerate holds busy while it gives one result per cycle in ascending key
// order, the final one marked by last, or one result with status empty on an
// empty table. Each result is valid for exactly one cycle while strobe is
// high; the receiver cannot stall it, and a new request may be taken in the
// cycle the last result of the previous one is shown.
// ----------------------------------------------------------------------------
module sorted_key_table_core import skt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [31:0] key,
	input  logic [31:0] payload,
	output logic        strobe,
	output logic [2:0]  status,
	output logic        found,
	output logic [31:0] entry_key,
	output logic [31:0] entry_data,
	output logic        last,
	output logic [6:0]  entries
);

	skt_cmd_t  cmd;
	skt_stat_t stat;

	// Sequence operations
	skt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Store entries and form results
	skt_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode),
		.key        (key),
		.payload    (payload),
		.cmd        (cmd),
		.stat       (stat),
		.strobe     (strobe),
		.status     (status),
		.found      (found),
		.entry_key  (entry_key),
		.entry_data (entry_data),
		.last       (last),
		.entries    (entries)
	);

endmodule

// File: rtl/core/skt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_ctrl: sequencing for the sorted key table
// Accepts a request, runs the binary search and resolve steps or the
// enumeration sweep, and reports busy while an operation is in progress.
// ----------------------------------------------------------------------------
module skt_ctrl import skt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] mode,
	input  skt_stat_t  stat,
	output skt_cmd_t   cmd,
	output logic       busy
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_ENUM   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	// Decode next state and datapath commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nx = (mode == MODE_ENUM) ? S_ENUM : S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (stat.search_done) begin
					cmd.resolve = 1'b1;
					state_nx    = S_IDLE;
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			S_ENUM: begin
				cmd.enum_step = 1'b1;
				if (stat.enum_last) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != S_IDLE);

	// A request is only taken from idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == S_IDLE))
		else $error("load issued outside idle");

	// Resolve returns the controller to idle on the next cycle
	a_resolve_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resolve |=> (state_q == S_IDLE))
		else $error("controller did not return to idle after resolve");

	// Commands are mutually exclusive
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command active");

endmodule

// File: rtl/core/skt_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_dpath: storage and result logic for the sorted key table
// Holds the ordered key and data lanes, the fill count, the binary search
// window and the registered result outputs.
// ----------------------------------------------------------------------------
module skt_dpath import skt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  mode,
	input  logic [31:0] key,
	input  logic [31:0] payload,
	input  skt_cmd_t    cmd,
	output skt_stat_t   stat,
	output logic        strobe,
	output logic [2:0]  status,
	output logic        found,
	output logic [31:0] entry_key,
	output logic [31:0] entry_data,
	output logic        last,
	output logic [6:0]  entries
);

	// Entry lanes, in ascending key order below the fill count
	logic [KEY_W-1:0]  key_q  [CAPACITY];
	logic [DATA_W-1:0] data_q [CAPACITY];
	logic [CNT_W-1:0]  fill_q;

	// Request and search window
	logic [1:0]        mode_q;
	logic [KEY_W-1:0]  kin_q;
	logic [DATA_W-1:0] din_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic [CNT_W-1:0]  idx_q;

	// Result registers
	logic              strobe_q;
	logic [2:0]        status_q;
	logic              found_q;
	logic [31:0]       ekey_q;
	logic [31:0]       edata_q;
	logic              last_q;
	logic [6:0]        entries_q;

	logic [CNT_W-1:0]  mid;
	logic [CNT_W-1:0]  rd_sel;
	logic [IDX_W-1:0]  rd_addr;
	logic [KEY_W-1:0]  rd_key;
	logic [DATA_W-1:0] rd_data;
	logic              hit;
	logic              do_ins;
	logic              do_rem;
	logic [2:0]        res_status;
	logic              res_found;
	logic [CNT_W-1:0]  fill_nx;

	// Midpoint of the search window
	assign mid = CNT_W'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

	// Single read port: enumeration index, search midpoint or final position
	always_comb begin
		if (cmd.enum_step) begin
			rd_sel = idx_q;
		end else if (cmd.search_step) begin
			rd_sel = mid;
		end else begin
			rd_sel = lo_q;
		end
	end

	assign rd_addr = rd_sel[IDX_W-1:0];
	assign rd_key  = key_q[rd_addr];
	assign rd_data = data_q[rd_addr];

	assign stat.search_done = (lo_q >= hi_q);
	assign stat.enum_last   = (fill_q == '0) || (CNT_W'(idx_q + 1'b1) == fill_q);

	// Decide the outcome once the lower bound is known
	assign hit = (lo_q < fill_q) && (rd_key == kin_q);

	always_comb begin
		do_ins     = 1'b0;
		do_rem     = 1'b0;
		res_status = ST_NOTFOUND;
		res_found  = 1'b0;
		case (mode_q)
			MODE_INSERT: begin
				if (kin_q == '0) begin
					res_status = ST_NOTFOUND;
				end else if (hit) begin
					res_status = ST_DUP;
				end else if (fill_q == CNT_W'(CAPACITY)) begin
					res_status = ST_FULL;
				end else begin
					res_status = ST_OK;
					do_ins     = 1'b1;
				end
			end
			MODE_REMOVE: begin
				if (hit) begin
					res_status = ST_OK;
					do_rem     = 1'b1;
				end
			end
			MODE_LOOKUP: begin
				if (hit) begin
					res_status = ST_OK;
					res_found  = 1'b1;
				end
			end
			default: begin
				res_status = ST_NOTFOUND;
			end
		endcase
	end

	always_comb begin
		fill_nx = fill_q;
		if (do_ins) begin
			fill_nx = CNT_W'(fill_q + 1'b1);
		end else if (do_rem) begin
			fill_nx = CNT_W'(fill_q - 1'b1);
		end
	end

	// Capture request and advance the search window
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			kin_q  <= key[KEY_W-1:0];
			din_q  <= payload[DATA_W-1:0];
			lo_q   <= '0;
			hi_q   <= fill_q;
			idx_q  <= '0;
		end else begin
			if (cmd.search_step) begin
				if (rd_key < kin_q) begin
					lo_q <= CNT_W'(mid + 1'b1);
				end else begin
					hi_q <= mid;
				end
			end
			if (cmd.enum_step) begin
				idx_q <= CNT_W'(idx_q + 1'b1);
			end
		end
	end

	// Hold fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.resolve) begin
			fill_q <= fill_nx;
		end
	end

	// Shift lanes up on insert, down on remove
	for (genvar g = 0; g < CAPACITY; g++) begin : g_lane
		logic above;
		logic at_pos;
		assign above  = (CNT_W'(g) > lo_q);
		assign at_pos = (CNT_W'(g) == lo_q);

		always_ff @(posedge clk) begin
			if (cmd.resolve && do_ins) begin
				if (at_pos) begin
					key_q[g]  <= kin_q;
					data_q[g] <= din_q;
				end else if (above) begin
					key_q[g]  <= key_q[(g > 0) ? g - 1 : 0];
					data_q[g] <= data_q[(g > 0) ? g - 1 : 0];
				end
			end else if (cmd.resolve && do_rem) begin
				if ((above || at_pos) && (g + 1 < CAPACITY)) begin
					key_q[g]  <= key_q[(g + 1 < CAPACITY) ? g + 1 : g];
					data_q[g] <= data_q[(g + 1 < CAPACITY) ? g + 1 : g];
				end
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.resolve | cmd.enum_step;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.resolve) begin
			status_q  <= res_status;
			found_q   <= res_found;
			ekey_q    <= res_found ? 32'(rd_key) : '0;
			edata_q   <= res_found ? 32'(rd_data) : '0;
			last_q    <= 1'b1;
			entries_q <= 7'(fill_nx);
		end else if (cmd.enum_step) begin
			found_q   <= 1'b0;
			entries_q <= 7'(fill_q);
			last_q    <= stat.enum_last;
			if (fill_q == '0) begin
				status_q <= ST_EMPTY;
				ekey_q   <= '0;
				edata_q  <= '0;
			end else begin
				status_q <= ST_OK;
				ekey_q   <= 32'(rd_key);
				edata_q  <= 32'(rd_data);
			end
		end
	end

	assign strobe     = strobe_q;
	assign status     = status_q;
	assign found      = found_q;
	assign entry_key  = ekey_q;
	assign entry_data = edata_q;
	assign last       = last_q;
	assign entries    = entries_q;

	// Fill count stays within capacity
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	// Search window lies within the filled part
	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.search_step |-> (lo_q < hi_q) && (hi_q <= fill_q))
		else $error("search window out of range");

	// A successful insert grows the table by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && mode_q == MODE_INSERT && status_q == ST_OK)
			|-> (fill_q == CNT_W'($past(fill_q) + 1'b1)))
		else $error("insert did not grow the table");

	// Enumeration emits keys in strictly ascending order
	a_enum_order: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && $past(strobe_q) && !$past(last_q) && mode_q == MODE_ENUM)
			|-> (ekey_q > $past(ekey_q)))
		else $error("enumeration out of order");

endmodule

// File: dv/tb_sorted_key_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_table_core: self-checking bench for the sorted key table
// Drives insert, remove, lookup and enumerate requests with random gaps. A
// shadow table holds the entries in ascending key order and predicts every
// response. Each strobed response is checked field by field against the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb_sorted_key_table_core;
	import skt_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 40;
	localparam int RAND_ITEMS  = 365;
	localparam int POOL_SIZE   = 32;

	// One request as queued for the driver, with the idle cycles before it
	typedef struct {
		logic [1:0]  op;
		logic [31:0] k;
		logic [31:0] d;
		int          gap;
	} table_req_t;

	// One response as the block should present it
	typedef struct {
		logic [2:0]  status;
		logic        found;
		logic [31:0] ekey;
		logic [31:0] edata;
		logic        last_flag;
		logic [6:0]  count;
	} table_resp_t;

	logic        clk;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	logic [1:0]  mode    = MODE_INSERT;
	logic [31:0] key     = '0;
	logic [31:0] payload = '0;
	logic        busy;
	logic        strobe;
	logic [2:0]  status;
	logic        found;
	logic [31:0] entry_key;
	logic [31:0] entry_data;
	logic        last;
	logic [6:0]  entries;

	table_req_t  req_q[$];
	table_resp_t exp_resp_q[$];

	// Shadow copy of the table contents
	logic [31:0] shadow_key[CAPACITY];
	logic [31:0] shadow_data[CAPACITY];
	int          shadow_fill = 0;

	logic [31:0] key_pool[POOL_SIZE];

	int n_total   = 0;
	int n_sent    = 0;
	int n_taken   = 0;
	int err_count = 0;
	int cycle_count = 0;

	// Driver staging
	table_req_t staged_req;
	logic       staged   = 1'b0;
	int         gap_left = 0;

	sorted_key_table_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.key       (key),
		.payload   (payload),
		.strobe    (strobe),
		.status    (status),
		.found     (found),
		.entry_key (entry_key),
		.entry_data(entry_data),
		.last      (last),
		.entries   (entries)
	);

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	function automatic int pick_gap(input logic quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	task automatic queue_req(input logic [1:0] op, input logic [31:0] k,
			input logic [31:0] d, input int gap);
		table_req_t r;
		r.op  = op;
		r.k   = k;
		r.d   = d;
		r.gap = gap;
		req_q.push_back(r);
	endtask

	task automatic push_resp(input logic [2:0] st, input logic fnd,
			input logic [31:0] k, input logic [31:0] d, input logic lst);
		table_resp_t r;
		r.status    = st;
		r.found     = fnd;
		r.ekey      = k;
		r.edata     = d;
		r.last_flag = lst;
		r.count     = 7'(shadow_fill);
		exp_resp_q.push_back(r);
	endtask

	// Apply one transfer to the shadow table and queue its responses
	task automatic apply_table_op(input logic [1:0] op, input logic [31:0] k,
			input logic [31:0] d);
		int  pos;
		logic hit;
		pos = 0;
		while (pos < shadow_fill && shadow_key[pos] < k)
			pos++;
		hit = (pos < shadow_fill) && (shadow_key[pos] == k);
		case (op)
			MODE_ENUM: begin
				if (shadow_fill == 0)
					push_resp(ST_EMPTY, 1'b0, '0, '0, 1'b1);
				else
					for (int i = 0; i < shadow_fill; i++)
						push_resp(ST_OK, 1'b0, shadow_key[i], shadow_data[i],
							i == shadow_fill - 1);
			end
			MODE_INSERT: begin
				if (k == '0)
					push_resp(ST_NOTFOUND, 1'b0, '0, '0, 1'b1);
				else if (hit)
					push_resp(ST_DUP, 1'b0, '0, '0, 1'b1);
				else if (shadow_fill >= CAPACITY)
					push_resp(ST_FULL, 1'b0, '0, '0, 1'b1);
				else begin
					for (int i = shadow_fill; i > pos; i--) begin
						shadow_key[i]  = shadow_key[i - 1];
						shadow_data[i] = shadow_data[i - 1];
					end
					shadow_key[pos]  = k;
					shadow_data[pos] = d;
					shadow_fill++;
					push_resp(ST_OK, 1'b0, '0, '0, 1'b1);
				end
			end
			MODE_REMOVE: begin
				if (!hit)
					push_resp(ST_NOTFOUND, 1'b0, '0, '0, 1'b1);
				else begin
					for (int i = pos; i + 1 < shadow_fill; i++) begin
						shadow_key[i]  = shadow_key[i + 1];
						shadow_data[i] = shadow_data[i + 1];
					end
					shadow_fill--;
					push_resp(ST_OK, 1'b0, '0, '0, 1'b1);
				end
			end
			default: begin
				if (hit)
					push_resp(ST_OK, 1'b1, shadow_key[pos], shadow_data[pos], 1'b1);
				else
					push_resp(ST_NOTFOUND, 1'b0, '0, '0, 1'b1);
			end
		endcase
	endtask

	// Random requests in phases that fill, drain or mix the table
	task automatic build_random_reqs();
		int          phase_kind;
		int          r;
		int          ins_w;
		int          rem_w;
		int          look_w;
		logic        quiet;
		logic [1:0]  op;
		logic [31:0] k;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		key_pool[2] = 32'h0000_0001;
		key_pool[3] = 32'h8000_0000;
		phase_kind = 0;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 30 == 0) begin
				// refresh part of the pool and choose the next phase
				for (int j = 0; j < 4; j++)
					key_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
				phase_kind = (n == 0) ? 0 : $urandom_range(0, 2);
				quiet      = ($urandom_range(0, 3) == 0);
			end
			case (phase_kind)
				0:       begin ins_w = 75; rem_w = 5;  look_w = 12; end
				1:       begin ins_w = 10; rem_w = 70; look_w = 12; end
				default: begin ins_w = 30; rem_w = 30; look_w = 32; end
			endcase
			r = $urandom_range(0, 99);
			if (r < ins_w)
				op = MODE_INSERT;
			else if (r < ins_w + rem_w)
				op = MODE_REMOVE;
			else if (r < ins_w + rem_w + look_w)
				op = MODE_LOOKUP;
			else
				op = MODE_ENUM;
			if ($urandom_range(0, 19) == 0)
				k = $urandom;
			else
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			queue_req(op, k, $urandom, pick_gap(quiet));
		end
	endtask

	// Drive requests at the falling edge; hold each until it is taken
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start   <= 1'b0;
			mode    <= MODE_INSERT;
			key     <= '0;
			payload <= '0;
		end else if (n_sent == n_taken) begin
			if (!staged && req_q.size() != 0) begin
				staged_req = req_q.pop_front();
				staged     = 1'b1;
				gap_left   = staged_req.gap;
			end
			if (staged && gap_left == 0) begin
				start   <= 1'b1;
				mode    <= staged_req.op;
				key     <= staged_req.k;
				payload <= staged_req.d;
				n_sent  <= n_sent + 1;
				staged  = 1'b0;
			end else begin
				// idle: put noise on the fields
				start   <= 1'b0;
				mode    <= 2'($urandom);
				key     <= $urandom;
				payload <= $urandom;
				if (staged)
					gap_left--;
			end
		end
	end

	// Check responses and predict accepted transfers at the rising edge
	always @(posedge clk) begin
		table_resp_t want;
		if (arst_n) begin
			if (strobe) begin
				if (exp_resp_q.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("ERROR: unexpected response status=%0d key=%h data=%h",
							status, entry_key, entry_data);
				end else begin
					want = exp_resp_q.pop_front();
					if (status !== want.status || found !== want.found ||
							entry_key !== want.ekey || entry_data !== want.edata ||
							last !== want.last_flag || entries !== want.count) begin
						err_count++;
						if (err_count <= 10)
							$display("ERROR: mismatch exp st=%0d fnd=%b key=%h data=%h",
								want.status, want.found, want.ekey, want.edata,
								" last=%b ent=%0d got st=%0d fnd=%b key=%h data=%h",
								want.last_flag, want.count, status, found, entry_key,
								entry_data, " last=%b ent=%0d", last, entries);
					end
				end
			end
			if (start && !busy) begin
				apply_table_op(mode, key, payload);
				n_taken <= n_taken + 1;
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		// directed: empty table, none key, key extremes, duplicate, misses
		queue_req(MODE_ENUM,   32'h0000_0005, 32'h0,         0);
		queue_req(MODE_LOOKUP, 32'h0000_0005, 32'h0,         0);
		queue_req(MODE_REMOVE, 32'h0000_0005, 32'h0,         1);
		queue_req(MODE_INSERT, 32'h0000_0000, 32'h1234_5678, 0);
		queue_req(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		queue_req(MODE_INSERT, 32'h0000_0001, 32'h0000_0000, 2);
		queue_req(MODE_INSERT, 32'h0000_0001, 32'hDEAD_BEEF, 0);
		queue_req(MODE_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 0);
		queue_req(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0,         0);
		queue_req(MODE_LOOKUP, 32'h0000_0001, 32'h0,         0);
		queue_req(MODE_LOOKUP, 32'h0000_0002, 32'h0,         0);
		queue_req(MODE_LOOKUP, 32'h0000_0000, 32'h0,         3);
		queue_req(MODE_REMOVE, 32'h0000_0000, 32'h0,         0);
		queue_req(MODE_ENUM,   32'h0000_0000, 32'h0,         0);
		queue_req(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0,         0);
		queue_req(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0,         0);
		queue_req(MODE_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 0);
		queue_req(MODE_ENUM,   32'h0000_0000, 32'h0,         0);
		build_random_reqs();
		n_total = req_q.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every transfer and response, then let stragglers show
		while (n_taken != n_total || exp_resp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
